// File: hw/rtl/tlvsp_pkg.sv
// package for the tlv stream parser
// holds phase encoding, result codes and the result record type; no dependencies
package tlvsp_pkg;

	localparam int TYPE_COUNT_DEF = 8;
	localparam logic [3:0] CODE_NONE = 4'd8;

	localparam logic [1:0] KIND_HDR  = 2'd0;
	localparam logic [1:0] KIND_DATA = 2'd1;
	localparam logic [1:0] KIND_END  = 2'd2;

	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_TRUNC   = 2'd1;
	localparam logic [1:0] STAT_PARTIAL = 2'd2;

	localparam int RES_DEPTH = 4;

	typedef enum logic [2:0] {
		PH_IDLE    = 3'd0,
		PH_TYPE_HI = 3'd1,
		PH_TYPE_LO = 3'd2,
		PH_LEN_HI  = 3'd3,
		PH_LEN_LO  = 3'd4,
		PH_DATA    = 3'd5,
		PH_STOP    = 3'd6
	} phase_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [3:0]  rtype;
		logic [15:0] rlen;
		logic [7:0]  rbyte;
		logic        rlast;
		logic [1:0]  status;
		logic        last;
	} result_t;

endpackage

// File: hw/rtl/tlv_stream_parser.sv
// tlv stream parser top level: input register, record state update, result queue
// depends on tlvsp_pkg
//
// One message byte is taken per transaction on the input channel and up to two
// transactions (a header or data result, then the end-of-message result) come
// out. A byte is registered, decoded against the record state and its results
// are written into a four-entry result queue; a byte can enter in every cycle
// while the queue holds at most two results, so a byte stream that yields one
// result per byte runs at one byte per clock while the output is not stalled,
// and the extra end result of each message takes an output slot of its own.
module tlv_stream_parser #(
	parameter int TYPE_COUNT = tlvsp_pkg::TYPE_COUNT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        msg_start,
	input  logic [15:0] msg_len,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [3:0]  record_type,
	output logic [15:0] record_len,
	output logic [7:0]  record_byte,
	output logic        record_last,
	output logic [1:0]  status,
	output logic        last
);

	localparam int PTR_W = $clog2(tlvsp_pkg::RES_DEPTH);
	localparam int CNT_W = PTR_W + 1;

	// input register
	logic        valid_s1;
	logic        start_s1;
	logic [15:0] mlen_s1;
	logic [7:0]  byte_s1;

	// record state
	tlvsp_pkg::phase_t phase_q;
	logic [15:0] bytes_left_q;
	logic [7:0]  type_high_q;
	logic [3:0]  type_code_q;
	logic [15:0] len_field_q;
	logic [15:0] data_left_q;
	logic        stopped_q;

	// result queue
	tlvsp_pkg::result_t res_q [tlvsp_pkg::RES_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	logic adv_s1;
	logic accept;
	logic pop;

	tlvsp_pkg::phase_t ph_e, ph_n;
	logic [15:0] bl_e, after;
	logic [7:0]  th_e, th_n;
	logic [3:0]  code_e, code_n;
	logic [15:0] len_e, len_n;
	logic [15:0] dl_e, dl_n;
	logic        stop_e, stop_n;
	logic        active;
	logic        emit_rec;
	logic        emit_end;
	logic [15:0] raw;
	logic [15:0] len_lo;
	tlvsp_pkg::result_t rec_res, end_res, first_res;
	logic [1:0]  push_n;

	assign adv_s1   = valid_s1 && (count_q <= CNT_W'(tlvsp_pkg::RES_DEPTH - 2));
	assign in_stall = valid_s1 && !adv_s1;
	assign accept   = in_valid && !in_stall;
	assign out_valid = (count_q != '0);
	assign pop      = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept || (valid_s1 && !adv_s1);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			start_s1 <= msg_start;
			mlen_s1  <= msg_len;
			byte_s1  <= data_byte;
		end
	end

	always_comb begin
		ph_e   = phase_q;
		bl_e   = bytes_left_q;
		th_e   = type_high_q;
		code_e = type_code_q;
		len_e  = len_field_q;
		dl_e   = data_left_q;
		stop_e = stopped_q;
		if (start_s1) begin
			bl_e   = (mlen_s1 == 16'd0) ? 16'd1 : mlen_s1;
			ph_e   = tlvsp_pkg::PH_TYPE_HI;
			stop_e = 1'b0;
			th_e   = 8'd0;
			code_e = tlvsp_pkg::CODE_NONE;
			len_e  = 16'd0;
			dl_e   = 16'd0;
		end
		active = start_s1 || (phase_q != tlvsp_pkg::PH_IDLE &&
			phase_q != tlvsp_pkg::PH_STOP + 3'd1 && bytes_left_q != 16'd0);
		after  = bl_e - 16'd1;
		raw    = {th_e, byte_s1};
		len_lo = {len_e[15:8], byte_s1};

		ph_n     = ph_e;
		th_n     = th_e;
		code_n   = code_e;
		len_n    = len_e;
		dl_n     = dl_e;
		stop_n   = stop_e;
		emit_rec = 1'b0;
		rec_res  = '0;

		case (ph_e)
			tlvsp_pkg::PH_TYPE_HI: begin
				th_n = byte_s1;
				ph_n = tlvsp_pkg::PH_TYPE_LO;
			end
			tlvsp_pkg::PH_TYPE_LO: begin
				code_n = (raw < 16'(TYPE_COUNT)) ? raw[3:0] : tlvsp_pkg::CODE_NONE;
				ph_n   = tlvsp_pkg::PH_LEN_HI;
			end
			tlvsp_pkg::PH_LEN_HI: begin
				len_n = {byte_s1, 8'd0};
				ph_n  = tlvsp_pkg::PH_LEN_LO;
			end
			tlvsp_pkg::PH_LEN_LO: begin
				len_n = len_lo;
				if (after < len_lo) begin
					stop_n = 1'b1;
					ph_n   = tlvsp_pkg::PH_STOP;
				end else begin
					emit_rec       = 1'b1;
					rec_res.kind   = tlvsp_pkg::KIND_HDR;
					rec_res.rtype  = code_e;
					rec_res.rlen   = len_lo;
					rec_res.rlast  = (len_lo == 16'd0);
					rec_res.status = tlvsp_pkg::STAT_OK;
					if (len_lo == 16'd0) begin
						ph_n = tlvsp_pkg::PH_TYPE_HI;
					end else begin
						dl_n = len_lo;
						ph_n = tlvsp_pkg::PH_DATA;
					end
				end
			end
			tlvsp_pkg::PH_DATA: begin
				emit_rec       = 1'b1;
				rec_res.kind   = tlvsp_pkg::KIND_DATA;
				rec_res.rtype  = code_e;
				rec_res.rlen   = len_e;
				rec_res.rbyte  = byte_s1;
				rec_res.rlast  = (dl_e == 16'd1);
				rec_res.status = tlvsp_pkg::STAT_OK;
				dl_n           = dl_e - 16'd1;
				if (dl_e == 16'd1) begin
					ph_n = tlvsp_pkg::PH_TYPE_HI;
				end
			end
			default: begin
			end
		endcase

		emit_end       = (after == 16'd0);
		end_res        = '0;
		end_res.kind   = tlvsp_pkg::KIND_END;
		end_res.rtype  = tlvsp_pkg::CODE_NONE;
		end_res.last   = 1'b1;
		if (stop_n) begin
			end_res.status = tlvsp_pkg::STAT_TRUNC;
		end else if (ph_n == tlvsp_pkg::PH_TYPE_LO || ph_n == tlvsp_pkg::PH_LEN_HI ||
				ph_n == tlvsp_pkg::PH_LEN_LO) begin
			end_res.status = tlvsp_pkg::STAT_PARTIAL;
		end else begin
			end_res.status = tlvsp_pkg::STAT_OK;
		end
		if (emit_end) begin
			ph_n   = tlvsp_pkg::PH_IDLE;
			stop_n = 1'b0;
		end

		rec_res.last = !emit_end;
		first_res    = emit_rec ? rec_res : end_res;
		if (!(adv_s1 && active)) begin
			push_n = 2'd0;
		end else begin
			push_n = 2'({1'b0, emit_rec} + {1'b0, emit_end});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= tlvsp_pkg::PH_IDLE;
			bytes_left_q <= 16'd0;
			type_high_q  <= 8'd0;
			type_code_q  <= tlvsp_pkg::CODE_NONE;
			len_field_q  <= 16'd0;
			data_left_q  <= 16'd0;
			stopped_q    <= 1'b0;
		end else if (adv_s1 && active) begin
			phase_q      <= ph_n;
			bytes_left_q <= after;
			type_high_q  <= th_n;
			type_code_q  <= code_n;
			len_field_q  <= len_n;
			data_left_q  <= dl_n;
			stopped_q    <= stop_n;
		end
	end

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			res_q[wr_ptr_q] <= first_res;
		end
		if (push_n == 2'd2) begin
			res_q[wr_ptr_q + PTR_W'(1)] <= end_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(push_n);
			rd_ptr_q <= rd_ptr_q + PTR_W'(pop);
			count_q  <= count_q + CNT_W'(push_n) - CNT_W'(pop);
		end
	end

	assign kind        = res_q[rd_ptr_q].kind;
	assign record_type = res_q[rd_ptr_q].rtype;
	assign record_len  = res_q[rd_ptr_q].rlen;
	assign record_byte = res_q[rd_ptr_q].rbyte;
	assign record_last = res_q[rd_ptr_q].rlast;
	assign status      = res_q[rd_ptr_q].status;
	assign last        = res_q[rd_ptr_q].last;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(tlvsp_pkg::RES_DEPTH))
		else $error("result queue overfilled");

	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind == tlvsp_pkg::KIND_END) |-> last)
		else $error("end of message result without last");

	a_stall_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && count_q > CNT_W'(tlvsp_pkg::RES_DEPTH - 2)) |-> in_stall)
		else $error("input taken with no queue room");

	a_phase_idle_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && active && emit_end) |=> (phase_q == tlvsp_pkg::PH_IDLE))
		else $error("parser not idle after end of message");

endmodule
